// ===== rtl/deq_pkg.sv =====
package deq_pkg;

	// Field widths fixed by the interface
	localparam int MODE_W  = 3;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;

	// Default ring depth
	localparam int DEPTH_DEF = 16;

	// Word reported for front and back while the queue is empty
	localparam logic signed [DATA_W-1:0] EMPTY_WORD = '1;

	// Request operation codes; unused codes act as a query
	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_QUERY      = 3'd4
	} mode_t;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_RESULT
	} state_t;

endpackage

// ===== rtl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit words kept in a ring of DEPTH entries.
// Input channel (in_valid / in_stall, fields mode and value): a request is
// taken at a rising edge with in_valid high and in_stall low. Modes are push
// front, push back, pop front, pop back and query; other codes act as query.
// Output channel (out_valid / out_stall): every request gives one result
// with the front and back words after the operation (-1 when empty), the
// count, an empty flag and an overflow flag for a push dropped on a full queue.
// Sequence: the request edge updates the pointers, writes the pushed word and
// reads the new front and back entries from the two-read-port ring memory;
// in ST_RESULT the output register is loaded once it is free. The block takes
// no new request until that load, as the ring memory's read is registered.
// in_stall is high while a request is in flight.
// When the receiver stalls, the result stays in the output register and the
// next request completes its work, then waits until the register frees up.
// Reset clears the front pointer, the count and the valid flags; the ring
// contents are not cleared, and only written entries are ever reported.
module double_ended_queue import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [MODE_W-1:0]        mode,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] front_value,
	output logic signed [DATA_W-1:0] back_value,
	output logic [COUNT_W-1:0]       count,
	output logic                     is_empty,
	output logic                     overflow
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 2;
	localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);

	// Ring position that lies ofs places after base (ofs <= DEPTH)
	function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
		input logic [CW-1:0] ofs);
		logic [SW-1:0] p;
		p = SW'(base) + SW'(ofs);
		if (p >= DEPTH_S) begin
			p = p - DEPTH_S;
		end
		return p[AW-1:0];
	endfunction

	state_t state_q, state_d;

	logic [AW-1:0] front_q;
	logic [CW-1:0] cnt_q;

	logic signed [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdf_q, rdb_q, word_q;
	logic                     fwdf_q, fwdb_q, ovf_q;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] front_value_q, back_value_q;
	logic [CW-1:0]            cnt_out_q;
	logic                     ovf_out_q;

	logic          in_acc, load;
	logic [AW-1:0] nf, wr_addr, ba;
	logic [CW-1:0] nc, back_ofs;
	logic          wr_en, ovf, full;
	logic signed [DATA_W-1:0] res_front, res_back;
	logic [CW+COUNT_W-1:0]    cnt_ext;

	assign in_acc = in_valid && !in_stall;
	assign full   = (cnt_q >= DEPTH_C);

	// Work out the new pointer, count and write slot for the request
	always_comb begin
		nf      = front_q;
		nc      = cnt_q;
		wr_en   = 1'b0;
		wr_addr = front_q;
		ovf     = 1'b0;
		case (mode)
			MODE_PUSH_FRONT: begin
				if (full) begin
					ovf = 1'b1;
				end else begin
					nf      = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
					wr_en   = 1'b1;
					wr_addr = nf;
					nc      = cnt_q + CW'(1);
				end
			end
			MODE_PUSH_BACK: begin
				if (full) begin
					ovf = 1'b1;
				end else begin
					wr_en   = 1'b1;
					wr_addr = ring_pos(front_q, cnt_q);
					nc      = cnt_q + CW'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (cnt_q != '0) begin
					nf = ring_pos(front_q, CW'(1));
					nc = cnt_q - CW'(1);
				end
			end
			MODE_POP_BACK: begin
				if (cnt_q != '0) begin
					nc = cnt_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
		back_ofs = (nc == '0) ? '0 : nc - CW'(1);
		ba       = ring_pos(nf, back_ofs);
	end

	// Write the pushed word and read the new front and back entries
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (wr_en) begin
				mem[wr_addr] <= value;
			end
			rdf_q  <= mem[nf];
			rdb_q  <= mem[ba];
			fwdf_q <= wr_en && (wr_addr == nf);
			fwdb_q <= wr_en && (wr_addr == ba);
			word_q <= value;
			ovf_q  <= ovf;
		end
	end

	// Advance pointer, count and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				front_q <= nf;
				cnt_q   <= nc;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_RESULT: begin
				load = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
	end

	// Pick forwarded or stored words; report -1 when empty
	assign res_front = (cnt_q == '0) ? EMPTY_WORD : (fwdf_q ? word_q : rdf_q);
	assign res_back  = (cnt_q == '0) ? EMPTY_WORD : (fwdb_q ? word_q : rdb_q);

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			front_value_q <= res_front;
			back_value_q  <= res_back;
			cnt_out_q     <= cnt_q;
			ovf_out_q     <= ovf_q;
		end
	end

	assign cnt_ext     = {{COUNT_W{1'b0}}, cnt_out_q};
	assign out_valid   = out_valid_q;
	assign front_value = front_value_q;
	assign back_value  = back_value_q;
	assign count       = cnt_ext[COUNT_W-1:0];
	assign is_empty    = (cnt_out_q == '0);
	assign overflow    = ovf_out_q;

endmodule
